>>> src/slseek_pkg.sv
// shared types, widths and codes of the sorted list seek block
package slseek_pkg;

  localparam int DEPTH_DEF  = 1024;
  localparam int LANES_DEF  = 16;

  localparam int ID_W       = 32;
  localparam int IDX_W      = 10;
  localparam int POS_W      = 11;
  localparam int LEN_W      = 11;
  localparam int LANE_IDX_W = 6;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SEEK = 1'b1;

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    logic                  hit;
    logic [LANE_IDX_W-1:0] lane;
  } lane_hit_t;

endpackage

>>> src/slseek_if.sv
// request and result channel interfaces
interface slseek_in_if;
  import slseek_pkg::*;

  logic valid;
  logic ready;
  logic opcode;
  idx_t write_index;
  id_t  id_value;
  pos_t seek_start;
  id_t  target;

  modport source (output valid, opcode, write_index, id_value, seek_start, target,
                  input ready);
  modport sink   (input valid, opcode, write_index, id_value, seek_start, target,
                  output ready);
endinterface

interface slseek_out_if;
  import slseek_pkg::*;

  logic valid;
  logic ready;
  pos_t position;
  logic found;

  modport source (output valid, position, found, input ready);
  modport sink   (input valid, position, found, output ready);
endinterface

>>> src/sorted_list_seek.sv
// top level: lower-bound seek over a row-organized id store
//
//   channel   dir   payload                                           handshake
//   items     in    opcode, write_index, id_value, seek_start, target valid/ready
//   results   out   position, found                                   valid/ready
//   cfg       in    cfg_wr_data (list_length)                         cfg_wr_en
//
// a seek passes through accept, an index split (skipped when LANES is a power
// of two, else a reciprocal multiply), setup, a scan of the store rows, each
// compared after its registered read, and the post of the result (a seek at
// or past the end skips to the post); one row read port bounds the scan.
// a load passes accept, index split and setup, and writes one lane of a row.
// reset is synchronous; it clears list_length and all control, not the store.
// one request is worked at a time; loads go on while a result waits to be taken.
module sorted_list_seek #(
  parameter int DEPTH = slseek_pkg::DEPTH_DEF,
  parameter int LANES = slseek_pkg::LANES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  slseek_pkg::len_t  cfg_wr_data,
  slseek_in_if.sink         items,
  slseek_out_if.source      results
);
  import slseek_pkg::*;

  localparam int ROWS      = (DEPTH + LANES - 1) / LANES;
  localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RCW       = $clog2(ROWS + 1);
  localparam int RMW       = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int LSH       = $clog2(LANES);
  localparam bit LANES_P2  = (LANES & (LANES - 1)) == 0;
  localparam int DEPTH_CAP = (DEPTH > 2047) ? 2047 : DEPTH;
  // exact floor(x / LANES) for any 11-bit x as (x * RECIP_M) >> RECIP_SH
  localparam int RECIP_SH  = POS_W + RMW;
  localparam int RECIP_W   = POS_W + 2;
  localparam int RECIP_M   = (2 ** RECIP_SH + LANES - 1) / LANES;
  localparam int PROD_W    = POS_W + RECIP_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]     state;
  len_t           list_length;
  len_t           len_eff;

  // latched request
  logic           op;
  pos_t           idx;
  id_t            value;

  // index split into row (quot) and lane (rmd)
  pos_t           quot;
  logic [RMW-1:0] rmd;
  logic [PROD_W-1:0] prod;
  pos_t           div_q;
  logic [RMW-1:0] div_r;

  // scan pipeline: read row, then compare the registered row data
  logic [RCW-1:0] rd_row;
  logic           rd_en;
  logic           cmp_valid;
  pos_t           cmp_base;
  len_t           cmp_remain;
  logic [RMW-1:0] lane_lo;

  logic [LANES-1:0][ID_W-1:0] row_data;
  lane_hit_t      hit;

  pos_t           res_pos;
  logic           res_found;
  logic           out_valid;
  pos_t           out_pos;
  logic           out_found;

  logic           wr_en;

  // a length beyond the store saturates at the store depth
  assign len_eff = (32'(list_length) > DEPTH) ? LEN_W'(DEPTH_CAP) : list_length;

  // index split by reciprocal multiply, remainder by multiply-back
  assign prod  = PROD_W'(quot) * PROD_W'(RECIP_M);
  assign div_q = POS_W'(prod >> RECIP_SH);
  assign div_r = RMW'(quot - POS_W'(div_q * POS_W'(LANES)));

  assign rd_en = (state == S_SCAN) && (rd_row < RCW'(ROWS));
  assign wr_en = (state == S_SETUP) && (op == OP_LOAD);

  assign items.ready      = (state == S_IDLE);
  assign results.valid    = out_valid;
  assign results.position = out_pos;
  assign results.found    = out_found;

  slseek_mem #(
    .LANES (LANES),
    .ROWS  (ROWS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_row  (RW'(quot)),
    .wr_lane (rmd),
    .wr_data (value),
    .rd_en   (rd_en),
    .rd_row  (RW'(rd_row)),
    .rd_data (row_data)
  );

  slseek_lanes #(
    .LANES (LANES)
  ) u_lanes (
    .row     (row_data),
    .target  (value),
    .lane_lo (lane_lo),
    .remain  (cmp_remain),
    .hit     (hit)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      list_length <= '0;
    end else if (cfg_wr_en) begin
      list_length <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // result taken by the sink; a new one posted this cycle takes its place
      if (out_valid && results.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (items.valid) begin
            op    <= items.opcode;
            value <= (items.opcode == OP_LOAD) ? items.id_value : items.target;
            if (items.opcode == OP_SEEK && items.seek_start >= len_eff) begin
              // start at or past the end: nothing to scan
              res_pos   <= len_eff;
              res_found <= 1'b0;
              state     <= S_DONE;
            end else if (items.opcode == OP_LOAD &&
                         32'(items.write_index) >= DEPTH) begin
              // load beyond the store is dropped
              state <= S_IDLE;
            end else begin
              if (items.opcode == OP_LOAD) begin
                idx <= POS_W'(items.write_index);
              end else begin
                idx <= items.seek_start;
              end
              if (LANES_P2) begin
                if (items.opcode == OP_LOAD) begin
                  quot <= POS_W'(POS_W'(items.write_index) >> LSH);
                  rmd  <= RMW'(POS_W'(items.write_index) & POS_W'(LANES - 1));
                end else begin
                  quot <= POS_W'(items.seek_start >> LSH);
                  rmd  <= RMW'(items.seek_start & POS_W'(LANES - 1));
                end
                state <= S_SETUP;
              end else begin
                if (items.opcode == OP_LOAD) begin
                  quot <= POS_W'(items.write_index);
                end else begin
                  quot <= items.seek_start;
                end
                rmd   <= '0;
                state <= S_DIV;
              end
            end
          end
        end

        S_DIV: begin
          // split the latched index into row and lane in one step
          quot  <= div_q;
          rmd   <= div_r;
          state <= S_SETUP;
        end

        S_SETUP: begin
          if (op == OP_LOAD) begin
            state <= S_IDLE;
          end else begin
            rd_row     <= RCW'(quot);
            cmp_valid  <= 1'b0;
            cmp_base   <= idx - POS_W'(rmd);
            cmp_remain <= len_eff - LEN_W'(idx - POS_W'(rmd));
            lane_lo    <= rmd;
            state      <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (rd_en) begin
            rd_row <= rd_row + 1'b1;
          end
          cmp_valid <= 1'b1;
          if (cmp_valid) begin
            if (hit.hit) begin
              res_pos   <= cmp_base + POS_W'(hit.lane);
              res_found <= 1'b1;
              state     <= S_DONE;
            end else if (cmp_remain <= LEN_W'(LANES)) begin
              // last row of the list, no match
              res_pos   <= len_eff;
              res_found <= 1'b0;
              state     <= S_DONE;
            end else begin
              cmp_base   <= cmp_base + POS_W'(LANES);
              cmp_remain <= cmp_remain - LEN_W'(LANES);
              lane_lo    <= '0;
            end
          end
        end

        S_DONE: begin
          // post once the output register is free
          if (!out_valid || results.ready) begin
            out_valid <= 1'b1;
            out_pos   <= res_pos;
            out_found <= res_found;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a match always lies inside the list
  a_found_inside: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.found) |-> (results.position < len_eff))
    else $error("found position outside list");

  // a miss always reports the list length
  a_miss_is_len: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.found) |-> (results.position == len_eff))
    else $error("miss position differs from list length");

  // row base and remaining count always add up to the list length
  a_scan_span: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ((12'(cmp_base) + 12'(cmp_remain)) == 12'(len_eff)))
    else $error("scan window lost track of list end");

  // a seek starting at or past the end goes straight to the result
  a_empty_seek: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready && items.opcode == OP_SEEK &&
     items.seek_start >= len_eff) |=> (state == S_DONE))
    else $error("empty seek did not complete at once");

endmodule

>>> src/slseek_mem.sv
// id store: rows of LANES ids, one lane write and one row read per cycle
module slseek_mem #(
  parameter int LANES = slseek_pkg::LANES_DEF,
  parameter int ROWS  = 64,
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int RMW  = (LANES > 1) ? $clog2(LANES) : 1
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [RW-1:0]                 wr_row,
  input  logic [RMW-1:0]                wr_lane,
  input  slseek_pkg::id_t               wr_data,
  input  logic                          rd_en,
  input  logic [RW-1:0]                 rd_row,
  output logic [LANES-1:0][slseek_pkg::ID_W-1:0] rd_data
);
  import slseek_pkg::*;

  logic [LANES-1:0][ID_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row][wr_lane] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

endmodule

>>> src/slseek_lanes.sv
// compares one row against the target and picks the lowest matching lane
module slseek_lanes #(
  parameter int LANES = slseek_pkg::LANES_DEF,
  localparam int RMW  = (LANES > 1) ? $clog2(LANES) : 1
) (
  input  logic [LANES-1:0][slseek_pkg::ID_W-1:0] row,
  input  slseek_pkg::id_t                        target,
  input  logic [RMW-1:0]                         lane_lo,
  input  slseek_pkg::len_t                       remain,
  output slseek_pkg::lane_hit_t                  hit
);
  import slseek_pkg::*;

  logic [LANES-1:0] match;

  // lane is live when at or above the start lane and below the list end
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      match[l] = (row[l] >= target) && (RMW'(l) >= lane_lo) && (LEN_W'(l) < remain);
    end
  end

  always_comb begin
    hit = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (match[l]) begin
        hit.hit  = 1'b1;
        hit.lane = LANE_IDX_W'(l);
      end
    end
  end

endmodule
